>>> hdl/kst_pkg.sv
// Shared types and status codes for the key state change table.
`timescale 1ns / 1ps

package kst_pkg;

    localparam int KEY_W = 16;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_KEY = 2'd1,
        ST_FULL    = 2'd2
    } kst_status_t;

    typedef struct packed {
        kst_status_t        status;
        logic               event_valid;
        logic [KEY_W-1:0]   event_key;
        logic               event_is_press;
    } kst_result_t;

endpackage

>>> hdl/kst_in_if.sv
// Input channel: one key report word per handshake.
`timescale 1ns / 1ps

interface kst_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] key_id;
    logic        pressed;

    modport source (output valid, output key_id, output pressed, input ready);
    modport sink   (input valid, input key_id, input pressed, output ready);
endinterface

>>> hdl/kst_out_if.sv
// Output channel: one status and event word per handshake.
`timescale 1ns / 1ps

interface kst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        event_valid;
    logic [15:0] event_key;
    logic        event_is_press;

    modport source (output valid, output status, output event_valid,
                    output event_key, output event_is_press, input ready);
    modport sink   (input valid, input status, input event_valid,
                    input event_key, input event_is_press, output ready);
endinterface

>>> hdl/kst_slot_mem.sv
// Slot memory: key code and last level per slot, one write and one registered read port.
`timescale 1ns / 1ps

module kst_slot_mem #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [kst_pkg::KEY_W-1:0] wr_key,
    input  logic                     wr_pressed,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic [kst_pkg::KEY_W-1:0] rd_key,
    output logic                     rd_pressed
);
    import kst_pkg::*;

    logic [KEY_W:0] mem [DEPTH];
    logic [KEY_W:0] rd_data_reg;

    // Write one slot, read one slot into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_pressed};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_key     = rd_data_reg[KEY_W:1];
    assign rd_pressed = rd_data_reg[0];

endmodule

>>> hdl/kst_ctrl.sv
// Scan sequencer: walks the occupied slots with one compare unit and updates the table.
`timescale 1ns / 1ps

module kst_ctrl #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    kst_in_if.sink                    in_ch,
    output kst_pkg::kst_result_t      res,
    output logic                      res_valid,
    input  logic                      res_taken,
    output logic [IDX_W-1:0]          rd_addr,
    input  logic [kst_pkg::KEY_W-1:0] rd_key,
    input  logic                      rd_pressed,
    output logic                      wr_en,
    output logic [IDX_W-1:0]          wr_addr,
    output logic [kst_pkg::KEY_W-1:0] wr_key,
    output logic                      wr_pressed
);
    import kst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              lvl_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              pend_reg;
    kst_result_t       res_reg;

    logic              hit;
    logic              last;
    logic              empty;
    logic              full;
    logic              miss;
    logic              accept;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign res         = res_reg;
    assign res_valid   = (state_reg == S_DONE);
    assign rd_addr     = rd_idx_reg;

    // Compare the slot read last cycle; the occupied slots form a prefix of the table
    assign hit   = pend_reg && (rd_key == key_reg);
    assign last  = pend_reg && (cmp_idx_reg == IDX_W'(fill_reg - CNT_W'(1)));
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign miss  = !hit && (empty || last);

    // Write back a changed level, or claim the next free slot on a miss
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = cmp_idx_reg;
        wr_key     = key_reg;
        wr_pressed = lvl_reg;
        if (state_reg == S_SCAN)
        begin
            if (hit)
            begin
                wr_en = (rd_pressed != lvl_reg);
            end
            else if (miss && !full)
            begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(fill_reg);
            end
        end
    end

    // Sequencer state, scan pointers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            key_reg     <= '0;
            lvl_reg     <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg    <= in_ch.key_id;
                        lvl_reg    <= in_ch.pressed;
                        rd_idx_reg <= '0;
                        pend_reg   <= 1'b0;
                        res_reg    <= '0;
                        if (in_ch.key_id == '0)
                        begin
                            res_reg.status <= ST_BAD_KEY;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_idx_reg  <= rd_idx_reg + IDX_W'(1);
                    cmp_idx_reg <= rd_idx_reg;
                    pend_reg    <= 1'b1;
                    if (hit)
                    begin
                        res_reg.status         <= ST_OK;
                        res_reg.event_valid    <= (rd_pressed != lvl_reg);
                        res_reg.event_key      <= (rd_pressed != lvl_reg) ? key_reg : '0;
                        res_reg.event_is_press <= (rd_pressed != lvl_reg) && lvl_reg;
                        state_reg              <= S_DONE;
                    end
                    else if (miss)
                    begin
                        if (full)
                        begin
                            res_reg.status <= ST_FULL;
                        end
                        else
                        begin
                            fill_reg               <= fill_reg + CNT_W'(1);
                            res_reg.status         <= ST_OK;
                            res_reg.event_valid    <= lvl_reg;
                            res_reg.event_key      <= lvl_reg ? key_reg : '0;
                            res_reg.event_is_press <= lvl_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_taken)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/key_state_change_table.sv
// Key state change table: a report with key code zero is answered with a bad-key status
// and no scan; any other key starts a scan that ends on a hit or, on a miss, after the last
// occupied slot (at most TABLE_ENTRIES slots), reading one slot per cycle through the
// single memory read port and one comparator.
// No new report is taken during a scan, nor until the result has moved to the output register.
// Reset empties the table by clearing the fill count; the slot memory itself is not swept.
`timescale 1ns / 1ps

module key_state_change_table #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    kst_in_if.sink    in_ch,
    kst_out_if.source out_ch
);
    import kst_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    kst_result_t       res;
    logic              res_valid;
    logic              res_taken;
    logic [IDX_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic              rd_pressed;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic              wr_pressed;

    logic              out_valid_reg;
    kst_result_t       out_word_reg;

    kst_ctrl #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .res        (res),
        .res_valid  (res_valid),
        .res_taken  (res_taken),
        .rd_addr    (rd_addr),
        .rd_key     (rd_key),
        .rd_pressed (rd_pressed),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_key     (wr_key),
        .wr_pressed (wr_pressed)
    );

    kst_slot_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_key     (wr_key),
        .wr_pressed (wr_pressed),
        .rd_addr    (rd_addr),
        .rd_key     (rd_key),
        .rd_pressed (rd_pressed)
    );

    // Move a finished result into the output register when it is free or draining
    assign res_taken = res_valid && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the output word until it is taken
    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_word_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = 2'(out_word_reg.status);
    assign out_ch.event_valid    = out_word_reg.event_valid;
    assign out_ch.event_key      = out_word_reg.event_key;
    assign out_ch.event_is_press = out_word_reg.event_is_press;

endmodule
